[hdl/srgb_transfer_convert_assert.svh]
// ----------------------------------------------------------------------------
// srgb transfer converter assertion macros
// Shared helpers that keep the assertion lines of the checker short.
// ----------------------------------------------------------------------------
`ifndef SRGB_TRANSFER_CONVERT_ASSERT_SVH
`define SRGB_TRANSFER_CONVERT_ASSERT_SVH

// property checked at every rising edge outside reset
`define STC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// value must not change in the cycle after cond
`define STC_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[hdl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// Types, fixed-point formats and power-segment tables of the sRGB converter.
// ----------------------------------------------------------------------------
package stc_pkg;

  // component format
  localparam int FRAC_BITS      = 12;
  localparam int TABLE_SEGMENTS = 64;
  localparam int IN_W           = 16;
  localparam int CW             = FRAC_BITS + 1;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam logic [CW-1:0] COLOR_ONE = CW'(ONE);
  localparam int CMP_W          = (IN_W > CW) ? IN_W : CW;

  // table format, signed Q.20 points
  localparam int     TW       = 20;
  localparam longint TONE     = longint'(1) << TW;
  localparam int     TVW      = TW + 2;
  localparam int     TAB_BITS = (TABLE_SEGMENTS + 1) * TVW;
  localparam int     IDX_W    = $clog2(TABLE_SEGMENTS);
  localparam int     TIX_W    = $clog2(TABLE_SEGMENTS + 1);
  localparam int     IDXF_W   = TIX_W + 1;
  localparam int     POS_W    = CW + TIX_W;

  // segment thresholds: linear segment when x is below these
  localparam int ENC_THR =
    int'((longint'(31308) * ONE + longint'(9999999)) / longint'(10000000));
  localparam int DEC_THR =
    int'((longint'(4045) * ONE + longint'(99999)) / longint'(100000));

  // linear segments, n = x*mul + add then n / div
  localparam int ENC_MUL = 1292;
  localparam int ENC_ADD = 50;
  localparam int ENC_DIV = 100;
  localparam int DEC_MUL = 100;
  localparam int DEC_ADD = 646;
  localparam int DEC_DIV = 1292;

  // reciprocal divide, exact for n below 2^LIN_NW and divisors above 2^6 and below 2^11
  localparam int LIN_NW = FRAC_BITS + 8;
  localparam int REC_S  = LIN_NW + 11;
  localparam int REC_W  = REC_S - 6;
  localparam int PROD_W = LIN_NW + REC_W;
  localparam int LIN_QW = PROD_W - REC_S;
  localparam longint ENC_REC = ((longint'(1) << REC_S) + ENC_DIV - 1) / ENC_DIV;
  localparam longint DEC_REC = ((longint'(1) << REC_S) + DEC_DIV - 1) / DEC_DIV;

  // interpolation widths
  localparam int PW    = TVW + CW + 1;
  localparam int SUM_W = PW + 1;
  localparam int RND_W = SUM_W - TW;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_e;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic en_a;
    logic en_b;
    logic en_c;
    logic en_d;
  } stc_en_t;

  // floor square root by bisection
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = '0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 21; k++) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // floor cube root by bisection
  function automatic logic [63:0] int_cbrt(input logic [63:0] n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = '0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 21; k++) begin
      mid = (lo + hi) >> 1;
      if (mid * mid * mid <= n) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // x^(5/12) in Q.20
  function automatic logic [63:0] root_5_12(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] p;
    r = int_cbrt(x << 40);
    r = int_sqrt(r << TW);
    r = int_sqrt(r << TW);
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r + (64'd1 << (TW - 1))) >> TW;
    end
    return p;
  endfunction

  // table points over [0,1], packed low point first
  function automatic logic [TAB_BITS-1:0] build_tab(input logic dec);
    logic [TAB_BITS-1:0] res;
    longint off;
    longint x;
    longint r;
    longint t;
    longint lo;
    longint hi;
    longint mid;
    longint v;
    res = '0;
    off = (55 * TONE + 500) / 1000;
    for (int i = 0; i <= TABLE_SEGMENTS; i++) begin
      x = (longint'(i) * TONE + TABLE_SEGMENTS / 2) / TABLE_SEGMENTS;
      if (!dec) begin
        r = longint'(root_5_12(64'(x)));
        v = (r * 1055 + 500) / 1000 - off;
      end else begin
        t = ((x + off) * 1000 + 527) / 1055;
        if (t > TONE) begin
          t = TONE;
        end
        lo = 0;
        hi = TONE + 1;
        for (int k = 0; k < 24; k++) begin
          if (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (longint'(root_5_12(64'(mid))) <= t) begin
              lo = mid;
            end else begin
              hi = mid;
            end
          end
        end
        v = lo;
      end
      res[i*TVW +: TVW] = TVW'(v);
    end
    return res;
  endfunction

  localparam logic [TAB_BITS-1:0] ENC_TAB = build_tab(1'b0);
  localparam logic [TAB_BITS-1:0] DEC_TAB = build_tab(1'b1);

endpackage

[hdl/stc_ctl.sv]
// ----------------------------------------------------------------------------
// stc_ctl
// Valid tracking and stall propagation for the four converter stages.
// ----------------------------------------------------------------------------
module stc_ctl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output stc_pkg::stc_en_t en_o
);
  import stc_pkg::*;

  logic va_q, vb_q, vc_q, vd_q;
  logic va_d, vb_d, vc_d, vd_d;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // a stage loads when it is empty or its content moves on
  assign rdy_d = !vd_q || !out_stall_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  always_comb begin
    va_d = rdy_a ? in_valid_i : va_q;
    vb_d = rdy_b ? va_q : vb_q;
    vc_d = rdy_c ? vb_q : vc_q;
    vd_d = rdy_d ? vc_q : vd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
      vc_q <= vc_d;
      vd_q <= vd_d;
    end
  end

  assign en_o.en_a  = rdy_a;
  assign en_o.en_b  = rdy_b;
  assign en_o.en_c  = rdy_c;
  assign en_o.en_d  = rdy_d;
  assign in_stall_o  = !rdy_a;
  assign out_valid_o = vd_q;

endmodule

[hdl/stc_lane.sv]
// ----------------------------------------------------------------------------
// stc_lane
// One colour component: clamp, table lookup, interpolation and output.
// ----------------------------------------------------------------------------
module stc_lane (
  input  logic                              clk_i,
  input  stc_pkg::stc_en_t                  en_i,
  input  stc_pkg::req_e                     req_i,
  input  logic signed [stc_pkg::IN_W-1:0]   x_i,
  output logic        [stc_pkg::CW-1:0]     y_o
);
  import stc_pkg::*;

  // stage a: clamp, segment select, table position
  logic              dec;
  logic [CMP_W-1:0]  mag_ext;
  logic [CW-1:0]     x_clamp;
  logic [POS_W-1:0]  pos;
  logic [IDXF_W-1:0] idx_full;
  logic [IDX_W-1:0]  idx_a_d, idx_a_q;
  logic [CW-1:0]     frac_a_d, frac_a_q;
  logic              lin_a_d, lin_a_q;
  logic [LIN_NW-1:0] num_a_d, num_a_q;
  logic              dec_a_q;

  always_comb begin
    dec     = (req_i == REQ_DECODE);
    mag_ext = CMP_W'(x_i[IN_W-2:0]);
    if (x_i[IN_W-1]) begin
      x_clamp = '0;
    end else if (mag_ext > CMP_W'(ONE)) begin
      x_clamp = COLOR_ONE;
    end else begin
      x_clamp = CW'(x_i[IN_W-2:0]);
    end

    pos      = POS_W'(x_clamp) * POS_W'(TABLE_SEGMENTS);
    idx_full = pos[POS_W-1:FRAC_BITS];
    // top end of the range uses the last segment at full weight
    if (idx_full >= IDXF_W'(TABLE_SEGMENTS)) begin
      idx_a_d  = IDX_W'(TABLE_SEGMENTS - 1);
      frac_a_d = COLOR_ONE;
    end else begin
      idx_a_d  = IDX_W'(idx_full);
      frac_a_d = {1'b0, pos[FRAC_BITS-1:0]};
    end

    if (dec) begin
      lin_a_d = (x_clamp < CW'(DEC_THR));
      num_a_d = LIN_NW'(LIN_NW'(x_clamp) * LIN_NW'(DEC_MUL)) + LIN_NW'(DEC_ADD);
    end else begin
      lin_a_d = (x_clamp < CW'(ENC_THR));
      num_a_d = LIN_NW'(LIN_NW'(x_clamp) * LIN_NW'(ENC_MUL)) + LIN_NW'(ENC_ADD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      dec_a_q  <= dec;
      lin_a_q  <= lin_a_d;
      idx_a_q  <= idx_a_d;
      frac_a_q <= frac_a_d;
      num_a_q  <= num_a_d;
    end
  end

  // stage b: table points and reciprocal divide
  logic        [TIX_W-1:0]  idx_nx;
  logic signed [TVW-1:0]    t0_b_d, t0_b_q;
  logic signed [TVW-1:0]    t1_b_d, t1_b_q;
  logic        [REC_W-1:0]  rec;
  logic        [PROD_W-1:0] prod;
  logic        [LIN_QW-1:0] q_b_d, q_b_q;
  logic        [CW-1:0]     frac_b_q;
  logic                     lin_b_q;

  always_comb begin
    idx_nx = TIX_W'(idx_a_q) + TIX_W'(1);
    if (dec_a_q) begin
      t0_b_d = DEC_TAB[idx_a_q*TVW +: TVW];
      t1_b_d = DEC_TAB[idx_nx*TVW +: TVW];
      rec    = REC_W'(DEC_REC);
    end else begin
      t0_b_d = ENC_TAB[idx_a_q*TVW +: TVW];
      t1_b_d = ENC_TAB[idx_nx*TVW +: TVW];
      rec    = REC_W'(ENC_REC);
    end
    prod  = PROD_W'(num_a_q) * PROD_W'(rec);
    q_b_d = prod[PROD_W-1:REC_S];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      t0_b_q   <= t0_b_d;
      t1_b_q   <= t1_b_d;
      q_b_q    <= q_b_d;
      frac_b_q <= frac_a_q;
      lin_b_q  <= lin_a_q;
    end
  end

  // stage c: weighted points
  logic        [CW-1:0]     wlo;
  logic signed [PW-1:0]     a_c_d, a_c_q;
  logic signed [PW-1:0]     b_c_d, b_c_q;
  logic        [LIN_QW-1:0] q_c_q;
  logic                     lin_c_q;

  always_comb begin
    wlo   = COLOR_ONE - frac_b_q;
    a_c_d = t0_b_q * $signed({1'b0, wlo});
    b_c_d = t1_b_q * $signed({1'b0, frac_b_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_c) begin
      a_c_q   <= a_c_d;
      b_c_q   <= b_c_d;
      q_c_q   <= q_b_q;
      lin_c_q <= lin_b_q;
    end
  end

  // stage d: sum, round, saturate, select segment
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] rnd;
  logic        [RND_W-1:0] shr;
  logic        [CW-1:0]    y_d, y_q;

  always_comb begin
    sum = SUM_W'(a_c_q) + SUM_W'(b_c_q);
    rnd = sum + SUM_W'(longint'(1) << (TW - 1));
    shr = rnd[SUM_W-1:TW];
    if (lin_c_q) begin
      if (q_c_q > LIN_QW'(ONE)) begin
        y_d = COLOR_ONE;
      end else begin
        y_d = CW'(q_c_q);
      end
    end else if (sum[SUM_W-1]) begin
      y_d = '0;
    end else if (shr > RND_W'(ONE)) begin
      y_d = COLOR_ONE;
    end else begin
      y_d = CW'(shr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_d) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[hdl/srgb_transfer_convert.sv]
// ----------------------------------------------------------------------------
// srgb_transfer_convert
// sRGB transfer function on RGBA pixels, both directions, one pixel a clock unless stalled.
//
// input channel: in_valid_i / in_stall_o carry req_type_i and the four
//   signed Q3.12 components; a transfer happens on a clock edge with valid
//   high and stall low. req_type_i low encodes linear light to sRGB, high
//   decodes sRGB to linear light. colour is clamped to [0,1], alpha is copied.
// output channel: out_valid_o / out_stall_i carry three 13-bit colour values
//   (4096 is 1.0) and the untouched alpha.
// stages: four register stages, a to d; the output is driven straight from
//   the stage d registers.
// throughput: one pixel per clock while the receiver is not stalling; every
//   stage then takes a new pixel each cycle.
// stall: a stalled result holds its value; empty stages ahead of it still
//   fill, so the input stalls only once all four stages hold pixels.
// reset: all stages empty, out_valid_o low and the input ready at once.
// ----------------------------------------------------------------------------
module srgb_transfer_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic signed [stc_pkg::IN_W-1:0] red_in_i,
  input  logic signed [stc_pkg::IN_W-1:0] green_in_i,
  input  logic signed [stc_pkg::IN_W-1:0] blue_in_i,
  input  logic signed [stc_pkg::IN_W-1:0] alpha_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic        [stc_pkg::CW-1:0]   red_out_o,
  output logic        [stc_pkg::CW-1:0]   green_out_o,
  output logic        [stc_pkg::CW-1:0]   blue_out_o,
  output logic signed [stc_pkg::IN_W-1:0] alpha_out_o
);
  import stc_pkg::*;

  stc_en_t en;
  req_e    req;

  // valid bits and per-stage load enables
  stc_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  // only bit 0 selects the direction
  assign req = req_e'(req_type_i);

  // one lane per colour component, all sharing the same enables
  stc_lane u_red (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (req),
    .x_i   (red_in_i),
    .y_o   (red_out_o)
  );

  stc_lane u_green (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (req),
    .x_i   (green_in_i),
    .y_o   (green_out_o)
  );

  stc_lane u_blue (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (req),
    .x_i   (blue_in_i),
    .y_o   (blue_out_o)
  );

  // alpha rides along the same four stages unchanged
  logic signed [IN_W-1:0] alpha_a_q, alpha_b_q, alpha_c_q, alpha_d_q;

  always_ff @(posedge clk_i) begin
    if (en.en_a) begin
      alpha_a_q <= alpha_in_i;
    end
    if (en.en_b) begin
      alpha_b_q <= alpha_a_q;
    end
    if (en.en_c) begin
      alpha_c_q <= alpha_b_q;
    end
    if (en.en_d) begin
      alpha_d_q <= alpha_c_q;
    end
  end

  assign alpha_out_o = alpha_d_q;

endmodule

[hdl/stc_chk.sv]
// ----------------------------------------------------------------------------
// stc_chk
// Port-level checks of the sRGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "srgb_transfer_convert_assert.svh"

module stc_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            req_type_i,
  input logic signed [stc_pkg::IN_W-1:0] red_in_i,
  input logic signed [stc_pkg::IN_W-1:0] green_in_i,
  input logic signed [stc_pkg::IN_W-1:0] blue_in_i,
  input logic signed [stc_pkg::IN_W-1:0] alpha_in_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic        [stc_pkg::CW-1:0]   red_out_o,
  input logic        [stc_pkg::CW-1:0]   green_out_o,
  input logic        [stc_pkg::CW-1:0]   blue_out_o,
  input logic signed [stc_pkg::IN_W-1:0] alpha_out_o
);
  import stc_pkg::*;

  logic [3*CW+IN_W-1:0] out_bus;
  logic [4*IN_W:0]      in_bus;
  logic                 out_held;
  logic                 in_held;
  logic                 in_take;
  logic                 color_ok;

  assign out_bus  = {red_out_o, green_out_o, blue_out_o, alpha_out_o};
  assign in_bus   = {req_type_i, red_in_i, green_in_i, blue_in_i, alpha_in_i};
  assign out_held = out_valid_o && out_stall_i;
  assign in_held  = in_valid_i && in_stall_o;
  assign in_take  = in_valid_i && !in_stall_o;
  assign color_ok = (red_out_o <= COLOR_ONE) && (green_out_o <= COLOR_ONE)
                 && (blue_out_o <= COLOR_ONE);

  // a stalled result stays offered
  `STC_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_held |=> out_valid_o, "stalled result dropped")

  // a stalled result keeps its value
  `STC_ASSERT_HOLD(a_out_data_hold, clk_i, rst_ni, out_held, out_bus, "stalled result changed")

  // a stalled input transfer keeps its payload
  `STC_ASSERT_HOLD(a_in_data_hold, clk_i, rst_ni, in_held, in_bus, "stalled transfer changed")

  // colour results never exceed one
  `STC_ASSERT(a_color_range, clk_i, rst_ni, out_valid_o |-> color_ok, "colour result above one")

  // with a free receiver a transfer comes out after four stages
  `STC_ASSERT(a_latency, clk_i, rst_ni, in_take ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o, "result missing after pipeline latency")

endmodule

bind srgb_transfer_convert stc_chk u_stc_chk (.*);

[bench/srgb_transfer_convert_tb.sv]
// ----------------------------------------------------------------------------
// srgb_transfer_convert_tb
// Self-checking bench for the sRGB converter: every accepted pixel is run
// through a bit-exact fixed-point model of both transfer curves, and each
// output pixel is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module srgb_transfer_convert_tb;
  import stc_pkg::*;

  // output pixel as the converter should deliver it
  typedef struct {
    logic [CW-1:0]          red;
    logic [CW-1:0]          green;
    logic [CW-1:0]          blue;
    logic signed [IN_W-1:0] alpha;
  } rgba_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   req_type_i;
  logic signed [IN_W-1:0] red_in_i;
  logic signed [IN_W-1:0] green_in_i;
  logic signed [IN_W-1:0] blue_in_i;
  logic signed [IN_W-1:0] alpha_in_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [CW-1:0]          red_out_o;
  logic [CW-1:0]          green_out_o;
  logic [CW-1:0]          blue_out_o;
  logic signed [IN_W-1:0] alpha_out_o;

  // power-segment curves in signed Q.20, point k sits at x = k/TABLE_SEGMENTS
  longint encode_curve [TABLE_SEGMENTS+1];
  longint decode_curve [TABLE_SEGMENTS+1];

  // pixels accepted by the converter whose results are still on the way
  rgba_result_t pending_pixels[$];

  // idle mix, in cycles per hundred
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  int pixels_sent;
  int encode_sent;
  int decode_sent;
  int pixels_checked;
  int drain_pauses;
  int mismatches;

  srgb_transfer_convert u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .alpha_in_i  (alpha_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .alpha_out_o (alpha_out_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // fixed-point model of the transfer curves
  // --------------------------------------------------------------------------

  // floor of the square root, or of the cube root when cube is set
  function automatic longint unsigned floor_root(input longint unsigned n, input bit cube);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned pw;
    lo = 0;
    hi = 64'd1 << 21;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      pw  = cube ? mid * mid * mid : mid * mid;
      if (pw <= n) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // x^(5/12) in Q.20: cube root, two square roots, then the fifth power with
  // round-half-up after every product
  function automatic longint unsigned pow_five_twelfths(input longint unsigned x);
    longint unsigned r;
    longint unsigned p;
    r = floor_root(x << 40, 1'b1);
    r = floor_root(r << TW, 1'b0);
    r = floor_root(r << TW, 1'b0);
    p = r;
    repeat (4) p = (p * r + (64'd1 << (TW - 1))) >> TW;
    return p;
  endfunction

  // one colour component through clamp, segment select and conversion
  function automatic logic [CW-1:0] srgb_convert_component(input req_e dir,
                                                           input logic signed [IN_W-1:0] raw);
    longint x;
    longint v;
    longint pos;
    longint f;
    int     seg;
    x = raw;
    if (x < 0) begin
      x = 0;
    end else if (x > ONE) begin
      x = ONE;
    end
    if (dir == REQ_ENCODE && x * 10000000 < longint'(31308) * ONE) begin
      v = (x * 1292 + 50) / 100;
    end else if (dir == REQ_DECODE && x * 100000 < longint'(4045) * ONE) begin
      v = (x * 100 + 646) / 1292;
    end else begin
      // table lookup with linear interpolation, the top end uses the last segment
      pos = x * TABLE_SEGMENTS;
      seg = int'(pos >> FRAC_BITS);
      f   = pos & (ONE - 1);
      if (seg >= TABLE_SEGMENTS) begin
        seg = TABLE_SEGMENTS - 1;
        f   = ONE;
      end
      if (dir == REQ_ENCODE) begin
        v = encode_curve[seg] * (ONE - f) + encode_curve[seg+1] * f;
      end else begin
        v = decode_curve[seg] * (ONE - f) + decode_curve[seg+1] * f;
      end
      // a negative blend near zero gives black
      if (v < 0) begin
        v = 0;
      end else begin
        v = (v + (longint'(1) << (TW - 1))) >> TW;
      end
    end
    if (v > ONE) begin
      v = ONE;
    end
    return CW'(v);
  endfunction

  // curves are fixed, so they are built once at time zero
  initial begin : build_curves
    longint offset;
    longint x;
    longint target;
    longint lo;
    longint hi;
    longint mid;
    offset = (55 * TONE + 500) / 1000;
    for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
      x = (longint'(k) * TONE + TABLE_SEGMENTS / 2) / TABLE_SEGMENTS;
      encode_curve[k] = (longint'(pow_five_twelfths(x)) * 1055 + 500) / 1000 - offset;
      // decode point: largest y whose root does not exceed (x+0.055)/1.055
      target = ((x + offset) * 1000 + 527) / 1055;
      if (target > TONE) begin
        target = TONE;
      end
      lo = 0;
      hi = TONE + 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (longint'(pow_five_twelfths(mid)) <= target) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      decode_curve[k] = lo;
    end
  end

  // --------------------------------------------------------------------------
  // result checking and receiver stalls
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("mismatch %s: want %0d got %0d (result %0d)", what, want, got, pixels_checked);
  endtask

  always @(posedge clk_i) begin : check_results
    rgba_result_t want;
    logic [IN_W-1:0] want_f [4];
    logic [IN_W-1:0] got_f [4];
    string field_name [4];
    field_name = '{"red", "green", "blue", "alpha"};
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want   = pending_pixels.pop_front();
        want_f = '{IN_W'(want.red), IN_W'(want.green), IN_W'(want.blue), want.alpha};
        got_f  = '{IN_W'(red_out_o), IN_W'(green_out_o), IN_W'(blue_out_o), alpha_out_o};
        for (int k = 0; k < 4; k++) begin
          if (got_f[k] !== want_f[k]) begin
            report_mismatch(field_name[k], want_f[k], got_f[k]);
          end
        end
        pixels_checked++;
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // one pixel transfer: optional idle cycles first, then hold the pixel until
  // the converter takes it and record what it should produce
  task automatic send_pixel(input req_e dir, input logic signed [IN_W-1:0] red,
                            input logic signed [IN_W-1:0] green,
                            input logic signed [IN_W-1:0] blue,
                            input logic signed [IN_W-1:0] alpha);
    rgba_result_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= dir;
    red_in_i   <= red;
    green_in_i <= green;
    blue_in_i  <= blue;
    alpha_in_i <= alpha;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    want.red   = srgb_convert_component(dir, red);
    want.green = srgb_convert_component(dir, green);
    want.blue  = srgb_convert_component(dir, blue);
    want.alpha = alpha;
    pending_pixels.push_back(want);
    pixels_sent++;
    if (dir == REQ_ENCODE) begin
      encode_sent++;
    end else begin
      decode_sent++;
    end
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
    drain_pauses++;
  endtask

  // component value biased toward the interesting regions of both curves
  function automatic logic signed [IN_W-1:0] pick_component();
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom_range(ONE);
      // around the encode and decode segment thresholds
      3:       v = ($urandom_range(1) ? 0 : 150) + $urandom_range(30);
      // on and next to the table points
      4:       v = int'($urandom_range(TABLE_SEGMENTS)) * (ONE / TABLE_SEGMENTS)
                   + int'($urandom_range(2)) - 1;
      5:       v = -int'($urandom_range(32768, 1));
      6:       v = $urandom_range(32767, ONE + 1);
      9:       v = $urandom_range(300);
      default: v = $urandom;
    endcase
    return IN_W'(v);
  endfunction

  // extremes of every field, both segment thresholds, the negative blend just
  // above the encode threshold, a table point, and clamping on both sides
  task automatic test_corner_values();
    logic signed [IN_W-1:0] corner [15];
    logic signed [IN_W-1:0] alpha_pick [5];
    req_e dir;
    corner = '{16'sd0, 16'sd1, 16'sd12, 16'sd13, 16'sd20, 16'sd64, 16'sd165, 16'sd166,
               16'sd2048, 16'sd4095, 16'sd4096, 16'sd4097, -16'sd1, -16'sd32768,
               16'sd32767};
    alpha_pick = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd4096};
    for (int d = 0; d < 2; d++) begin
      dir = d ? REQ_DECODE : REQ_ENCODE;
      for (int rot = 0; rot < 2; rot++) begin
        for (int j = 0; j < 5; j++) begin
          send_pixel(dir, corner[3*j + rot], corner[(3*j + 1 + rot) % 15],
                     corner[(3*j + 2 + rot) % 15], alpha_pick[(j + rot) % 5]);
        end
      end
    end
  endtask

  task automatic test_random_pixels(input int count);
    req_e dir;
    for (int n = 0; n < count; n++) begin
      dir = $urandom_range(1) ? REQ_DECODE : REQ_ENCODE;
      send_pixel(dir, pick_component(), pick_component(), pick_component(), IN_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // run sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    req_type_i         = 1'b0;
    red_in_i           = '0;
    green_in_i         = '0;
    blue_in_i          = '0;
    alpha_in_i         = '0;
    sender_idle_pct    = 7;
    receiver_stall_pct = 70;
    pixels_sent        = 0;
    encode_sent        = 0;
    decode_sent        = 0;
    pixels_checked     = 0;
    drain_pauses       = 0;
    mismatches         = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // busy sender, heavily stalling receiver
    test_corner_values();
    wait_drained();
    test_random_pixels(310);
    wait_drained();

    // bursty sender against a mostly ready receiver
    sender_idle_pct    = 70;
    receiver_stall_pct = 7;
    test_random_pixels(310);
    wait_drained();

    // full rate on both sides
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_pixels(310);
    wait_drained();

    // pipeline is four stages deep; anything showing up now is spurious
    repeat (32) @(posedge clk_i);

    $display("converted %0d pixels (%0d encode, %0d decode), %0d results checked",
             pixels_sent, encode_sent, decode_sent, pixels_checked);
    $display("three idle mixes, %0d full drains, %0d mismatches", drain_pauses, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
